### sv/gtd_pkg.sv
// ---------------------------------------------------------------------------
// gtd_pkg
// Shared types, constants and tables of the Goertzel tone detector.
// ---------------------------------------------------------------------------
`default_nettype none

package gtd_pkg;

   localparam int StateBits  = 48;
   localparam int CoefBits   = 18;
   localparam int LenBits    = 13;
   localparam int SampleBits = 16;
   localparam int MagBits    = 16;
   localparam int PhaseBits  = 17;
   localparam int MaxBlock   = 4096;
   localparam int CordicIters = 24;
   localparam int IterBits   = 5;
   localparam int VecBits    = 52;
   localparam int AngBits    = 28;
   localparam int DivBits    = 36;
   localparam int DivCntBits = 6;

   localparam logic [1:0] CSR_COS = 2'd0;
   localparam logic [1:0] CSR_SIN = 2'd1;
   localparam logic [1:0] CSR_LEN = 2'd2;

   localparam logic signed [AngBits-1:0] AngPi = 28'sd16777216;
   localparam logic [29:0] InvGainQ30 = 30'd652032874;

   // one finished block, handed from the resonator to the back end
   typedef struct packed {
      logic [StateBits-1:0] r;
      logic [StateBits-1:0] xi;
      logic [LenBits-1:0]   n;
   } blk_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic signed [AngBits-1:0] atan_lut(input logic [IterBits-1:0] i);
      logic signed [AngBits-1:0] v;
      case (i)
         5'd0:  v = 28'sd4194304;
         5'd1:  v = 28'sd2476042;
         5'd2:  v = 28'sd1308273;
         5'd3:  v = 28'sd664100;
         5'd4:  v = 28'sd333338;
         5'd5:  v = 28'sd166832;
         5'd6:  v = 28'sd83436;
         5'd7:  v = 28'sd41721;
         5'd8:  v = 28'sd20861;
         5'd9:  v = 28'sd10430;
         5'd10: v = 28'sd5215;
         5'd11: v = 28'sd2608;
         5'd12: v = 28'sd1304;
         5'd13: v = 28'sd652;
         5'd14: v = 28'sd326;
         5'd15: v = 28'sd163;
         5'd16: v = 28'sd81;
         5'd17: v = 28'sd41;
         5'd18: v = 28'sd20;
         5'd19: v = 28'sd10;
         5'd20: v = 28'sd5;
         5'd21: v = 28'sd3;
         5'd22: v = 28'sd1;
         5'd23: v = 28'sd1;
         default: v = 28'sd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### sv/gtd_front.sv
// ---------------------------------------------------------------------------
// gtd_front
// Resonator front end: takes samples, runs the recurrence on a shared
// 25x18 multiplier and queues R and X at the end of each block.
// ---------------------------------------------------------------------------
`default_nettype none

module gtd_front
   import gtd_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [SampleBits-1:0]      req_tdata,
   input  wire  signed [CoefBits-1:0] cos_coeff,
   input  wire  signed [CoefBits-1:0] sin_coeff,
   input  wire  [LenBits-1:0]         block_length,
   input  q_stat_type                 q_stat,
   output logic                       push,
   output blk_type                    push_blk
);

   typedef enum logic [8:0] {
      F_IDLE = 9'b000000001,
      F_PLO  = 9'b000000010,
      F_PHI  = 9'b000000100,
      F_UPD  = 9'b000001000,
      F_RLO  = 9'b000010000,
      F_RHI  = 9'b000100000,
      F_XLO  = 9'b001000000,
      F_XHI  = 9'b010000000,
      F_PUSH = 9'b100000000
   } fst_type;

   fst_type                     st_ff, st_in;
   logic [StateBits-1:0]        d1_ff, d1_in, d2_ff, d2_in, r_ff, r_in;
   logic [LenBits-1:0]          cnt_ff, cnt_in, n_ff, n_in, eff_n, cnt_inc;
   logic [SampleBits-1:0]       smp_ff, smp_in;
   logic signed [42:0]          prod_ff, prod_in, acc_ff, acc_in;
   logic signed [24:0]          mul_a;
   logic signed [CoefBits-1:0]  mul_c;
   logic signed [65:0]          full;
   logic [StateBits-1:0]        xs, y;

   // clamp the block length to one..MaxBlock
   always_comb begin
      if (block_length == '0) begin
         eff_n = LenBits'(1);
      end else if (block_length > LenBits'(MaxBlock)) begin
         eff_n = LenBits'(MaxBlock);
      end else begin
         eff_n = block_length;
      end
   end

   // pick the delay half and coefficient for the shared multiplier;
   // hold the sine product steady while the push waits
   always_comb begin
      if (st_ff == F_PLO || st_ff == F_RLO || st_ff == F_XLO) begin
         mul_a = $signed({1'b0, d1_ff[23:0]});
      end else begin
         mul_a = $signed({d1_ff[47], d1_ff[47:24]});
      end
      mul_c = (st_ff == F_XLO || st_ff == F_XHI || st_ff == F_PUSH) ? sin_coeff : cos_coeff;
      prod_in = mul_a * mul_c;
   end

   assign full    = 66'(acc_ff) + (66'(prod_ff) <<< 24);
   assign xs      = {{(StateBits-SampleBits-16){smp_ff[SampleBits-1]}}, smp_ff, 16'd0};
   assign y       = xs + full[62:15] - d2_ff;
   assign cnt_inc = cnt_ff + LenBits'(1);

   assign req_tready = (st_ff == F_IDLE);
   assign push       = (st_ff == F_PUSH) && !q_stat.full;
   assign push_blk   = '{r: r_ff, xi: full[63:16], n: n_ff};

   // sequence one sample, and the closing products at block end
   always_comb begin
      st_in  = st_ff;
      d1_in  = d1_ff;
      d2_in  = d2_ff;
      r_in   = r_ff;
      cnt_in = cnt_ff;
      n_in   = n_ff;
      smp_in = smp_ff;
      acc_in = acc_ff;
      unique case (st_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               smp_in = req_tdata;
               st_in  = F_PLO;
            end
         end
         F_PLO: st_in = F_PHI;
         F_PHI: begin
            acc_in = prod_ff;
            st_in  = F_UPD;
         end
         F_UPD: begin
            d1_in = y;
            d2_in = d1_ff;
            n_in  = eff_n;
            if (cnt_inc >= eff_n) begin
               cnt_in = '0;
               st_in  = F_RLO;
            end else begin
               cnt_in = cnt_inc;
               st_in  = F_IDLE;
            end
         end
         F_RLO: st_in = F_RHI;
         F_RHI: begin
            acc_in = prod_ff;
            st_in  = F_XLO;
         end
         F_XLO: begin
            r_in  = full[63:16] - d2_ff;
            st_in = F_XHI;
         end
         F_XHI: begin
            acc_in = prod_ff;
            st_in  = F_PUSH;
         end
         F_PUSH: begin
            if (!q_stat.full) begin
               d1_in = '0;
               d2_in = '0;
               st_in = F_IDLE;
            end
         end
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= F_IDLE;
         d1_ff  <= '0;
         d2_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         d1_ff  <= d1_in;
         d2_ff  <= d2_in;
         cnt_ff <= cnt_in;
      end
      r_ff    <= r_in;
      n_ff    <= n_in;
      smp_ff  <= smp_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

### sv/gtd_queue.sv
// ---------------------------------------------------------------------------
// gtd_queue
// Two-entry queue of finished blocks between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module gtd_queue
   import gtd_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        push,
   input  blk_type    push_blk,
   input  wire        pop,
   output blk_type    pop_blk,
   output q_stat_type q_stat
);

   blk_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign q_stat.full  = (cnt_ff == 2'd2);
   assign q_stat.empty = (cnt_ff == 2'd0);
   assign pop_blk      = mem_ff[rp_ff];

   // write the entry, advance pointers and hold the fill count
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_blk;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

`default_nettype wire

### sv/gtd_back.sv
// ---------------------------------------------------------------------------
// gtd_back
// Back end: CORDIC vectoring for angle and length, gain removal,
// bit-serial divide by the block length and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module gtd_back
   import gtd_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  q_stat_type           q_stat,
   input  blk_type              pop_blk,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [MagBits-1:0]   mag,
   output logic [PhaseBits-1:0] phase
);

   typedef enum logic [6:0] {
      B_IDLE = 7'b0000001,
      B_PRE  = 7'b0000010,
      B_ROT  = 7'b0000100,
      B_MUL  = 7'b0001000,
      B_SUM  = 7'b0010000,
      B_DIV  = 7'b0100000,
      B_OUT  = 7'b1000000
   } bst_type;

   bst_type                    st_ff, st_in;
   logic signed [VecBits-1:0]  x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [AngBits-1:0]  z_ff, z_in, zc, t;
   logic                       zero_ff, zero_in, ovf_ff, ovf_in, vld_ff, vld_in;
   logic [LenBits-1:0]         n_ff, n_in;
   logic [IterBits-1:0]        it_ff, it_in;
   logic [DivCntBits-1:0]      dc_ff, dc_in;
   logic [60:0]                hi_ff, hi_in;
   logic [49:0]                lo_ff, lo_in;
   logic [60:0]                m1;
   logic [DivBits-1:0]         d_ff, d_in;
   logic [LenBits-1:0]         rem_ff, rem_in;
   logic [LenBits:0]           trial;
   logic [MagBits-1:0]         q_ff, q_in, mag_ff, mag_in;
   logic [PhaseBits-1:0]       ph_ff, ph_in;

   assign pop        = (st_ff == B_IDLE) && !q_stat.empty;
   assign rsp_tvalid = vld_ff;
   assign mag        = mag_ff;
   assign phase      = ph_ff;

   assign dx    = y_ff >>> it_ff;
   assign dy    = x_ff >>> it_ff;
   assign m1    = hi_ff + 61'(lo_ff >> 20);
   assign trial = {rem_ff, d_ff[DivBits-1]};

   // clamp the angle, add a quarter turn and round to pi/32768 units
   always_comb begin
      if (z_ff > AngPi) begin
         zc = AngPi;
      end else if (z_ff < -AngPi) begin
         zc = -AngPi;
      end else begin
         zc = z_ff;
      end
      t = zc + (AngPi >>> 1) + AngBits'(256) + (AngPi <<< 2);
   end

   always_comb begin
      st_in   = st_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      n_in    = n_ff;
      it_in   = it_ff;
      dc_in   = dc_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      mag_in  = mag_ff;
      ph_in   = ph_ff;
      vld_in  = vld_ff && !rsp_tready;
      unique case (st_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               x_in    = VecBits'($signed(pop_blk.r));
               y_in    = VecBits'($signed(pop_blk.xi));
               zero_in = (pop_blk.r == '0) && (pop_blk.xi == '0);
               n_in    = pop_blk.n;
               z_in    = '0;
               st_in   = B_PRE;
            end
         end
         // fold the left half plane onto the right
         B_PRE: begin
            it_in = '0;
            if (zero_ff) begin
               x_in  = '0;
               st_in = B_MUL;
            end else begin
               if (x_ff < 0) begin
                  z_in = (y_ff >= 0) ? AngPi : -AngPi;
                  x_in = -x_ff;
                  y_in = -y_ff;
               end
               st_in = B_ROT;
            end
         end
         // one vectoring micro-rotation per cycle
         B_ROT: begin
            if (y_ff >= 0) begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + atan_lut(it_ff);
            end else begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - atan_lut(it_ff);
            end
            it_in = it_ff + IterBits'(1);
            if (it_ff == IterBits'(CordicIters - 1)) begin
               st_in = B_MUL;
            end
         end
         // remove the CORDIC gain in two partial products
         B_MUL: begin
            hi_in = 61'(x_ff[50:20]) * 61'(InvGainQ30);
            lo_in = 50'(x_ff[19:0]) * 50'(InvGainQ30);
            st_in = B_SUM;
         end
         B_SUM: begin
            d_in   = m1[60:25];
            rem_in = '0;
            q_in   = '0;
            ovf_in = 1'b0;
            dc_in  = '0;
            st_in  = B_DIV;
         end
         // restoring divide by the block length, one bit a cycle
         B_DIV: begin
            d_in   = d_ff << 1;
            ovf_in = ovf_ff | q_ff[MagBits-1];
            if (trial >= {1'b0, n_ff}) begin
               rem_in = LenBits'(trial - {1'b0, n_ff});
               q_in   = {q_ff[MagBits-2:0], 1'b1};
            end else begin
               rem_in = trial[LenBits-1:0];
               q_in   = {q_ff[MagBits-2:0], 1'b0};
            end
            dc_in = dc_ff + DivCntBits'(1);
            if (dc_ff == DivCntBits'(DivBits - 1)) begin
               st_in = B_OUT;
            end
         end
         // load the result register once it is free
         B_OUT: begin
            if (!vld_ff || rsp_tready) begin
               mag_in = ovf_ff ? '1 : q_ff;
               ph_in  = t[25:9];
               vld_in = 1'b1;
               st_in  = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= B_IDLE;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         vld_ff <= vld_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      zero_ff <= zero_in;
      n_ff    <= n_in;
      it_ff   <= it_in;
      dc_ff   <= dc_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      ovf_ff  <= ovf_in;
      mag_ff  <= mag_in;
      ph_ff   <= ph_in;
   end

endmodule

`default_nettype wire

### sv/goertzel_tone_detector_unit.sv
// ---------------------------------------------------------------------------
// goertzel_tone_detector_unit
// Single-bin Goertzel detector: resonator front end, block queue and
// CORDIC/divider back end giving magnitude and phase per block.
// ---------------------------------------------------------------------------
//  channel | direction | contents
//  req_    | in        | one sample word
//  rsp_    | out       | magnitude and phase, one word per block
//  csr_    | in        | cos_coeff, sin_coeff, block_length writes
//
// A sample takes two multiplier passes over the 48-bit delay in the resonator;
// the last sample of a block also runs the closing products and a queue slot.
// The back end runs 24 CORDIC steps and 36 divide steps per block, and skips
// the CORDIC steps for a zero vector; it hides behind blocks of 15 samples or more.
// Reset is synchronous and clears delays, count and queue; a full queue holds
// the front end at the block-end push, and with it the input.
`default_nettype none

module goertzel_tone_detector_unit
   import gtd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [15:0] sample
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] magnitude, [32:16] phase
   input  wire         csr_we,
   input  wire  [1:0]  csr_addr,
   input  wire  [17:0] csr_wdata
);

   logic signed [CoefBits-1:0] cos_ff, sin_ff;
   logic [LenBits-1:0]         len_ff;
   logic                       push, pop;
   blk_type                    push_blk, pop_blk;
   q_stat_type                 q_stat;
   logic [MagBits-1:0]         mag;
   logic [PhaseBits-1:0]       phase;

   // take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= 18'sh10000;
         sin_ff <= '0;
         len_ff <= LenBits'(256);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_COS: cos_ff <= csr_wdata;
            CSR_SIN: sin_ff <= csr_wdata;
            CSR_LEN: len_ff <= csr_wdata[LenBits-1:0];
            default: ;
         endcase
      end
   end

   gtd_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .cos_coeff(cos_ff), .sin_coeff(sin_ff), .block_length(len_ff),
      .q_stat, .push, .push_blk
   );

   gtd_queue u_queue (
      .clock, .reset, .push, .push_blk, .pop, .pop_blk, .q_stat
   );

   gtd_back u_back (
      .clock, .reset, .q_stat, .pop_blk, .pop,
      .rsp_tvalid, .rsp_tready, .mag, .phase
   );

   assign rsp_tdata = {7'd0, phase, mag};

   // never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full)) else $error("push into full queue");

   // never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_stat.empty)) else $error("pop from empty queue");

   // phase stays within a quarter turn either side of the half circle
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(phase) >= -17'sd16384) && ($signed(phase) <= 17'sd49152))
      else $error("phase out of range");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid) else $error("result after reset");

endmodule

`default_nettype wire

### test/tb_goertzel_tone_detector_unit.sv
// ---------------------------------------------------------------------------
// tb_goertzel_tone_detector_unit
// Self-checking bench for the Goertzel tone detector. A directed table covers
// the coefficient and block-length extremes, the zero vector, saturation,
// length clamping and a length lowered mid-block. Random blocks follow under
// three idling patterns. Result words are checked against a bit-true
// resonator/CORDIC predictor kept inside the bench, or against fixed values in typed rows.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_goertzel_tone_detector_unit;
   import gtd_pkg::*;

   localparam int          CycleLimit = 2000000;
   localparam int          SettleCycles = 20;
   localparam int          DrainCycles = 200;
   localparam longint      AngleHalfTurn = 64'sd16777216;
   localparam longint unsigned GainInv = 64'd652032874;
   localparam longint      ArcTab [24] = '{
      4194304, 2476042, 1308273, 664100, 333338, 166832, 83436, 41721,
      20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1, 1};

   typedef enum logic {ROW_CSR, ROW_SMP} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   addr;
      logic [17:0]  val;
      bit           typed;
      logic [15:0]  mag;
      logic [16:0]  ph;
   } stim_row_type;

   typedef struct {
      logic [15:0] mag;
      logic [16:0] ph;
   } tone_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] sample
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [15:0] magnitude, [32:16] phase
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [17:0] csr_wdata;

   // bench copy of the block state and registers
   logic [47:0] res_d1, res_d2;
   int          res_count;
   logic [17:0] reg_cos, reg_sin;
   logic [12:0] reg_len;

   tone_type    tone_q[$];
   int          mismatches;
   int          cycles;
   int          send_idle, recv_idle;

   goertzel_tone_detector_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // floor(a*c / 2^sh), wrapped to 48 bits
   function automatic logic [47:0] coef_scale(logic [47:0] a, logic [17:0] c, int sh);
      logic signed [65:0] p;
      p = $signed(a) * $signed(c);
      return 48'(p >> sh);
   endfunction

   // vector length and angle of R + jX, scaled to the result word
   function automatic tone_type tone_of(logic [47:0] r, logic [47:0] xi, int n);
      longint          x, y, z, dx, dy, t;
      longint unsigned ux, m1, mg;
      tone_type        o;
      x  = $signed(r);
      y  = $signed(xi);
      z  = 0;
      mg = 0;
      if (x != 0 || y != 0) begin
         if (x < 0) begin
            z = (y >= 0) ? AngleHalfTurn : -AngleHalfTurn;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += ArcTab[i];
            end else begin
               x -= dx; y += dy; z -= ArcTab[i];
            end
         end
         if (z > AngleHalfTurn) z = AngleHalfTurn;
         if (z < -AngleHalfTurn) z = -AngleHalfTurn;
         ux = x;
         m1 = (ux >> 20) * GainInv + (((ux & 64'hFFFFF) * GainInv) >> 20);
         mg = m1 / (longint'(n) << 25);
         if (mg > 65535) mg = 65535;
      end
      t     = z + AngleHalfTurn / 2 + 256 + 4 * AngleHalfTurn;
      o.mag = mg[15:0];
      o.ph  = 17'((t >>> 9) - 131072);
      return o;
   endfunction

   // advance the resonator by one sample; returns 1 with a result at block end
   function automatic bit resonate(logic [15:0] s, output tone_type o);
      logic [47:0] y;
      int          n;
      y = {{16{s[15]}}, s, 16'h0} + coef_scale(res_d1, reg_cos, 15) - res_d2;
      n = (reg_len == 0) ? 1 : (reg_len > MaxBlock) ? MaxBlock : int'(reg_len);
      res_d2 = res_d1;
      res_d1 = y;
      res_count++;
      if (res_count < n) return 1'b0;
      o = tone_of(coef_scale(res_d1, reg_cos, 16) - res_d2,
                  coef_scale(res_d1, reg_sin, 16), n);
      res_d1 = '0;
      res_d2 = '0;
      res_count = 0;
      return 1'b1;
   endfunction

   // hold until every expected word is in, then let the front end settle
   task automatic wait_quiet();
      while (tone_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] a, logic [17:0] v);
      csr_we    = 1'b1;
      csr_addr  = a;
      csr_wdata = v;
      @(negedge clock);
      csr_we    = 1'b0;
      case (a)
         CSR_COS: reg_cos = v;
         CSR_SIN: reg_sin = v;
         CSR_LEN: reg_len = v[12:0];
         default: ;
      endcase
   endtask

   // offer one sample word; called and left at a falling edge
   task automatic send_sample(logic [15:0] s, bit typed, tone_type fixed);
      tone_type o;
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid = 1'b1;
      req_tdata  = s;
      do @(posedge clock); while (!req_tready);
      if (resonate(s, o)) tone_q.push_back(typed ? fixed : o);
      @(negedge clock);
   endtask

   task automatic run_random(int items);
      int          sent, len, nsmp;
      logic [17:0] c;
      logic [15:0] s;
      sent = 0;
      while (sent < items) begin
         req_tvalid = 1'b0;
         wait_quiet();
         for (int k = 0; k < 2; k++) begin
            case ($urandom_range(9))
               0:       c = 18'h10000;
               1:       c = 18'h30000;
               2:       c = 18'($urandom);
               default: c = 18'(int'($urandom_range(131072)) - 65536);
            endcase
            write_reg(k ? CSR_SIN : CSR_COS, c);
         end
         len = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
         if ($urandom_range(15) == 0) len = 0;
         write_reg(CSR_LEN, 18'(len));
         if (len == 0) len = 1;
         nsmp = $urandom_range(1, 4) * len;
         if ($urandom_range(4) == 0) nsmp += $urandom_range(0, len - 1);
         repeat (nsmp) begin
            case ($urandom_range(7))
               0:       s = 16'h8000;
               1:       s = 16'h7FFF;
               default: s = 16'($urandom);
            endcase
            send_sample(s, 1'b0, '{default: '0});
            sent++;
         end
      end
      req_tvalid = 1'b0;
   endtask

   // directed table: zero vector, saturation, coefficient and length extremes
   stim_row_type plan [] = '{
      '{ROW_CSR, CSR_LEN, 18'd1,       0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_COS, 18'd0,       0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h07FFF,   1, 16'd0, 17'd16384},
      '{ROW_SMP, 2'd0,    18'h08000,   1, 16'd0, 17'd16384},
      '{ROW_CSR, CSR_SIN, 18'h10000,   0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h08000,   1, 16'd65535, 17'd0},
      '{ROW_SMP, 2'd0,    18'h07FFF,   0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_COS, 18'h30000,   0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_SIN, 18'h30000,   0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h00001,   0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h08000,   0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_COS, 18'h1FFFF,   0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_SIN, 18'h20000,   0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_LEN, 18'd3,       0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h07FFF,   0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h07FFF,   0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h07FFF,   0, 16'd0, 17'd0},
      '{ROW_CSR, 2'd3,    18'h3FFFF,   0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_LEN, 18'd0,       0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h00064,   0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_LEN, 18'h01FFF,   0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h00005,   0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h0FFFB,   0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_LEN, 18'd2,       0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h00007,   0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_LEN, 18'd4096,    0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h00001,   0, 16'd0, 17'd0},
      '{ROW_CSR, CSR_LEN, 18'd1,       0, 16'd0, 17'd0},
      '{ROW_SMP, 2'd0,    18'h00000,   0, 16'd0, 17'd0}
   };

   // main sequence
   initial begin
      tone_type fixed;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      res_d1     = '0;
      res_d2     = '0;
      res_count  = 0;
      reg_cos    = 18'h10000;
      reg_sin    = '0;
      reg_len    = 13'd256;
      mismatches = 0;
      send_idle  = 13;
      recv_idle  = 70;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            req_tvalid = 1'b0;
            wait_quiet();
            write_reg(plan[i].addr, plan[i].val);
         end else begin
            fixed.mag = plan[i].mag;
            fixed.ph  = plan[i].ph;
            send_sample(plan[i].val[15:0], plan[i].typed, fixed);
         end
      end
      req_tvalid = 1'b0;

      run_random(620);
      send_idle = 70;
      recv_idle = 13;
      run_random(610);
      send_idle = 0;
      recv_idle = 0;
      run_random(620);

      // drain and settle
      while (tone_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && tone_q.size() == 0) begin
         $display("PASS goertzel_tone_detector_unit");
      end else begin
         $display("FAIL goertzel_tone_detector_unit");
      end
      $finish;
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      tone_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tone_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: mag %0d phase %0d",
                        rsp_tdata[15:0], $signed(rsp_tdata[32:16]));
         end else begin
            want = tone_q.pop_front();
            if (rsp_tdata[15:0] !== want.mag || rsp_tdata[32:16] !== want.ph) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: mag exp %0d got %0d, phase exp %0d got %0d",
                           want.mag, rsp_tdata[15:0], $signed(want.ph),
                           $signed(rsp_tdata[32:16]));
            end
         end
      end
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CycleLimit) begin
            $display("FAIL goertzel_tone_detector_unit");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
